>>> src/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg: shared types and constants of the indexed list store
// Operation and status codes, cell control word and request/result structs.
// ----------------------------------------------------------------------------
package ilst_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  // wide enough for any index or count up to the largest capacity
  localparam int WIDE_W   = 9;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_SET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_GET    = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD       = 3'd0,
    CM_ROTATE     = 3'd1,
    CM_SHIFT_UP   = 3'd2,
    CM_SHIFT_DOWN = 3'd3,
    CM_WRITE      = 3'd4
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e                mode;
    logic [POS_W-1:0]          pos;
    logic signed [DATA_W-1:0]  data;
  } cell_ctrl_t;

  typedef struct packed {
    op_e                       operation;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic [5:0]                found_position;
    logic [6:0]                count;
    logic                      is_empty;
    logic signed [DATA_W-1:0]  first_value;
    logic signed [DATA_W-1:0]  last_value;
  } rsp_t;

endpackage

>>> src/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell: one storage cell of the list chain
// Holds one entry and picks its next value from itself, a neighbor or the
// request data, depending on the broadcast control word and its own index.
// ----------------------------------------------------------------------------
module ilst_cell #(
  parameter int IDX = 0
) (
  input  logic                                  clk_i,
  input  ilst_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [ilst_pkg::DATA_W-1:0]    lower_i,
  input  logic signed [ilst_pkg::DATA_W-1:0]    upper_i,
  output logic signed [ilst_pkg::DATA_W-1:0]    value_o,
  output logic signed [ilst_pkg::DATA_W-1:0]    next_o
);

  localparam logic [ilst_pkg::POS_W-1:0] MyIdx = ilst_pkg::POS_W'(IDX);

  logic signed [ilst_pkg::DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.mode)
      ilst_pkg::CM_ROTATE: begin
        value_d = upper_i;
      end
      ilst_pkg::CM_SHIFT_UP: begin
        if (MyIdx > ctrl_i.pos) begin
          value_d = lower_i;
        end else if (MyIdx == ctrl_i.pos) begin
          value_d = ctrl_i.data;
        end
      end
      ilst_pkg::CM_SHIFT_DOWN: begin
        if (MyIdx >= ctrl_i.pos) begin
          value_d = upper_i;
        end
      end
      ilst_pkg::CM_WRITE: begin
        if (MyIdx == ctrl_i.pos) begin
          value_d = ctrl_i.data;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign next_o  = value_d;

endmodule

>>> src/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top: bounded ordered list of signed 32-bit values
// A request is taken while idle; the ring of cells then rotates once past the
// head cell to read, search and find the last entry, and the result is
// registered in the execute state. busy is high from the accepting edge until
// the result is out, and no new request is taken meanwhile.
// The result shows for one cycle on done_o; the receiver cannot stall.
// Reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
  parameter int CAPACITY = ilst_pkg::CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ilst_pkg::req_t   req_i,
  output logic             done_o,
  output ilst_pkg::rsp_t   rsp_o
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int WW   = ilst_pkg::WIDE_W;
  localparam int DW   = ilst_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  state_e                 state_q;
  ilst_pkg::req_t         req_q;
  logic [IDXW-1:0]        step_q;
  logic [CNTW-1:0]        count_q;
  logic signed [DW-1:0]   sel_q, last_q, prev_q;
  logic                   hit_q;
  logic [IDXW-1:0]        hit_idx_q;
  logic                   done_q;
  ilst_pkg::rsp_t         rsp_q, rsp_d;

  logic signed [DW-1:0]   cell_val [CAPACITY];
  logic signed [DW-1:0]   cell_nxt [CAPACITY];
  ilst_pkg::cell_ctrl_t   cell_ctrl;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilst_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .lower_i (cell_val[(g + CAPACITY - 1) % CAPACITY]),
      .upper_i (cell_val[(g + 1) % CAPACITY]),
      .value_o (cell_val[g]),
      .next_o  (cell_nxt[g])
    );
  end

  // decode of the held request against the pre-operation state
  logic [WW-1:0]             count9, pos9, step9, new_cnt9, found9;
  logic                      full, pos_lt_cnt, is_last_pos;
  ilst_pkg::status_e         status_x;
  ilst_pkg::cell_mode_e      mode_x;
  logic [ilst_pkg::POS_W-1:0] eff_pos;
  logic signed [DW-1:0]      data_x, last_new, head;
  logic                      scan_last, scan_prev, scan_sel, scan_hit;

  always_comb begin
    count9      = WW'(count_q);
    pos9        = WW'(req_q.position);
    step9       = WW'(step_q);
    full        = (count9 == WW'(CAPACITY));
    pos_lt_cnt  = (pos9 < count9);
    is_last_pos = ((pos9 + WW'(1)) == count9);
    head        = cell_val[0];

    scan_sel  = (step9 == pos9);
    scan_last = ((step9 + WW'(1)) == count9);
    scan_prev = ((step9 + WW'(2)) == count9);
    scan_hit  = (req_q.operation == ilst_pkg::OP_FIND) && !hit_q &&
                (step9 < count9) && (head == req_q.data_in);

    status_x = ilst_pkg::ST_OK;
    mode_x   = ilst_pkg::CM_HOLD;
    eff_pos  = req_q.position;
    new_cnt9 = count9;
    data_x   = '0;
    found9   = '0;
    last_new = last_q;

    case (req_q.operation)
      ilst_pkg::OP_APPEND: begin
        if (full) begin
          status_x = ilst_pkg::ST_FULL;
        end else begin
          mode_x   = ilst_pkg::CM_SHIFT_UP;
          eff_pos  = count9[ilst_pkg::POS_W-1:0];
          new_cnt9 = count9 + WW'(1);
          last_new = req_q.data_in;
        end
      end
      ilst_pkg::OP_INSERT: begin
        if (full) begin
          status_x = ilst_pkg::ST_FULL;
        end else if (pos9 > count9) begin
          status_x = ilst_pkg::ST_RANGE;
        end else begin
          mode_x   = ilst_pkg::CM_SHIFT_UP;
          new_cnt9 = count9 + WW'(1);
          if (pos9 == count9) begin
            last_new = req_q.data_in;
          end
        end
      end
      ilst_pkg::OP_SET: begin
        if (!pos_lt_cnt) begin
          status_x = ilst_pkg::ST_RANGE;
        end else begin
          mode_x = ilst_pkg::CM_WRITE;
          if (is_last_pos) begin
            last_new = req_q.data_in;
          end
        end
      end
      ilst_pkg::OP_REMOVE: begin
        if (!pos_lt_cnt) begin
          status_x = ilst_pkg::ST_RANGE;
        end else begin
          mode_x   = ilst_pkg::CM_SHIFT_DOWN;
          new_cnt9 = count9 - WW'(1);
          data_x   = sel_q;
          // removing the tail makes the entry below it the new tail
          if (is_last_pos) begin
            last_new = prev_q;
          end
        end
      end
      ilst_pkg::OP_GET: begin
        if (!pos_lt_cnt) begin
          status_x = ilst_pkg::ST_RANGE;
        end else begin
          data_x = sel_q;
        end
      end
      ilst_pkg::OP_FIND: begin
        if (hit_q) begin
          found9 = WW'(hit_idx_q);
        end else begin
          status_x = ilst_pkg::ST_NOTFOUND;
        end
      end
      ilst_pkg::OP_CLEAR: begin
        new_cnt9 = '0;
      end
      default: begin
        status_x = ilst_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    cell_ctrl.pos  = eff_pos;
    cell_ctrl.data = req_q.data_in;
    case (state_q)
      S_SCAN:  cell_ctrl.mode = ilst_pkg::CM_ROTATE;
      S_EXEC:  cell_ctrl.mode = mode_x;
      default: cell_ctrl.mode = ilst_pkg::CM_HOLD;
    endcase
  end

  always_comb begin
    rsp_d.status         = status_x;
    rsp_d.data_out       = data_x;
    rsp_d.found_position = found9[5:0];
    rsp_d.count          = new_cnt9[6:0];
    rsp_d.is_empty       = (new_cnt9 == '0);
    rsp_d.first_value    = (new_cnt9 == '0) ? '0 : cell_nxt[0];
    rsp_d.last_value     = (new_cnt9 == '0) ? '0 : last_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      step_q    <= '0;
      count_q   <= '0;
      sel_q     <= '0;
      last_q    <= '0;
      prev_q    <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            step_q  <= '0;
            hit_q   <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // the head cell holds entry step_q during this cycle
          if (scan_sel) begin
            sel_q <= head;
          end
          if (scan_last) begin
            last_q <= head;
          end
          if (scan_prev) begin
            prev_q <= head;
          end
          if (scan_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= step_q;
          end
          if (step_q == IDXW'(CAPACITY - 1)) begin
            state_q <= S_EXEC;
          end else begin
            step_q <= step_q + IDXW'(1);
          end
        end
        S_EXEC: begin
          count_q <= new_cnt9[CNTW-1:0];
          rsp_q   <= rsp_d;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(CAPACITY + 2) done_o)
    else $error("result strobe missing after request");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

endmodule

>>> bench/tb_indexed_list_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top: self-checking bench for the indexed list store
// Sends list requests under the start/busy handshake with random gaps and
// keeps its own copy of the list. Every done_o strobe is checked field by
// field against the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LATENCY     = ilst_pkg::CAPACITY + 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  ilst_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  ilst_pkg::rsp_t rsp_o;

  // shadow copy of the list
  logic signed [ilst_pkg::DATA_W-1:0] list_cells [ilst_pkg::CAPACITY];
  int                                 list_len;
  ilst_pkg::rsp_t                     list_reports [$];
  int                                 error_count = 0;
  int                                 idle_pct    = 28;

  indexed_list_store_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_indexed_list_store_top NOT OK");
    $finish;
  end

  // apply one request to the shadow list and report the state after it
  function automatic ilst_pkg::rsp_t list_apply(ilst_pkg::req_t r);
    ilst_pkg::rsp_t res;
    int   p;
    int   i;
    res        = '0;
    res.status = ilst_pkg::ST_OK;
    p          = r.position;
    case (r.operation)
      ilst_pkg::OP_APPEND: begin
        if (list_len >= ilst_pkg::CAPACITY) begin
          res.status = ilst_pkg::ST_FULL;
        end else begin
          list_cells[list_len] = r.data_in;
          list_len++;
        end
      end
      ilst_pkg::OP_INSERT: begin
        if (list_len >= ilst_pkg::CAPACITY) begin
          res.status = ilst_pkg::ST_FULL;
        end else if (p > list_len) begin
          res.status = ilst_pkg::ST_RANGE;
        end else begin
          for (i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = r.data_in;
          list_len++;
        end
      end
      ilst_pkg::OP_SET: begin
        if (p >= list_len) res.status = ilst_pkg::ST_RANGE;
        else list_cells[p] = r.data_in;
      end
      ilst_pkg::OP_REMOVE: begin
        if (p >= list_len) begin
          res.status = ilst_pkg::ST_RANGE;
        end else begin
          res.data_out = list_cells[p];
          for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      ilst_pkg::OP_GET: begin
        if (p >= list_len) res.status = ilst_pkg::ST_RANGE;
        else res.data_out = list_cells[p];
      end
      ilst_pkg::OP_FIND: begin
        res.status = ilst_pkg::ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_cells[i] == r.data_in) begin
            res.status         = ilst_pkg::ST_OK;
            res.found_position = 6'(i);
            break;
          end
        end
      end
      ilst_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count    = 7'(list_len);
    res.is_empty = (list_len == 0);
    if (list_len != 0) begin
      res.first_value = list_cells[0];
      res.last_value  = list_cells[list_len-1];
    end
    return res;
  endfunction

  function automatic ilst_pkg::req_t make_req(ilst_pkg::op_e op, int pos,
                                              logic signed [ilst_pkg::DATA_W-1:0] val);
    ilst_pkg::req_t r;
    r.operation = op;
    r.position  = ilst_pkg::POS_W'(pos);
    r.data_in   = val;
    return r;
  endfunction

  function automatic logic signed [ilst_pkg::DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    // small values give plenty of duplicates for find
    if (roll < 30) return $signed($urandom_range(0, 8)) - 4;
    if (roll < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic int pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, list_len);
    if (roll < 90) return (list_len < 255) ? list_len + $urandom_range(0, 1) : list_len;
    return $urandom_range(0, 255);
  endfunction

  // start stays high from one request to the next unless a gap is taken
  task automatic send_request(input ilst_pkg::req_t r);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(5, LATENCY + 6)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    list_reports = {list_reports, list_apply(r)};
  endtask

  function automatic void check_field(string name, logic [ilst_pkg::DATA_W-1:0] want,
                                      logic [ilst_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    ilst_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (list_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, rsp_o);
        error_count++;
      end else begin
        want = list_reports.pop_front();
        check_field("status", ilst_pkg::DATA_W'(want.status),
                    ilst_pkg::DATA_W'(rsp_o.status));
        check_field("data_out", want.data_out, rsp_o.data_out);
        check_field("found_position", ilst_pkg::DATA_W'(want.found_position),
                    ilst_pkg::DATA_W'(rsp_o.found_position));
        check_field("count", ilst_pkg::DATA_W'(want.count), ilst_pkg::DATA_W'(rsp_o.count));
        check_field("is_empty", ilst_pkg::DATA_W'(want.is_empty),
                    ilst_pkg::DATA_W'(rsp_o.is_empty));
        check_field("first_value", want.first_value, rsp_o.first_value);
        check_field("last_value", want.last_value, rsp_o.last_value);
      end
    end
  end

  // each access but append on a list that was just reset
  task automatic test_empty_list();
    send_request(make_req(ilst_pkg::OP_GET, 0, 0));
    send_request(make_req(ilst_pkg::OP_REMOVE, 0, 0));
    send_request(make_req(ilst_pkg::OP_SET, 0, 32'sd9));
    send_request(make_req(ilst_pkg::OP_FIND, 0, 32'sd5));
    send_request(make_req(ilst_pkg::OP_INSERT, 1, 32'sd3));
    send_request(make_req(ilst_pkg::OP_NOP, 255, -32'sd1));
    send_request(make_req(ilst_pkg::OP_CLEAR, 0, 0));
  endtask

  task automatic test_edit_ops();
    send_request(make_req(ilst_pkg::OP_APPEND, 0, 32'sh7fffffff));
    send_request(make_req(ilst_pkg::OP_APPEND, 0, 32'sh80000000));
    send_request(make_req(ilst_pkg::OP_INSERT, 0, -32'sd1));
    // index equal to count appends, one past it is out of range
    send_request(make_req(ilst_pkg::OP_INSERT, 3, 32'sd0));
    send_request(make_req(ilst_pkg::OP_INSERT, 5, 32'sd7));
    send_request(make_req(ilst_pkg::OP_INSERT, 1, 32'sh55555555));
    send_request(make_req(ilst_pkg::OP_SET, 2, 32'shaaaaaaaa));
    send_request(make_req(ilst_pkg::OP_GET, 4, 0));
    send_request(make_req(ilst_pkg::OP_GET, 5, 0));
    send_request(make_req(ilst_pkg::OP_APPEND, 0, 32'sd0));
    // two zeros now, the lower index wins
    send_request(make_req(ilst_pkg::OP_FIND, 0, 32'sd0));
    send_request(make_req(ilst_pkg::OP_REMOVE, 5, 0));
    send_request(make_req(ilst_pkg::OP_REMOVE, 0, 0));
    send_request(make_req(ilst_pkg::OP_REMOVE, 2, 0));
    send_request(make_req(ilst_pkg::OP_FIND, 0, 32'sh7fffffff));
    send_request(make_req(ilst_pkg::OP_GET, 255, 0));
    send_request(make_req(ilst_pkg::OP_SET, 255, 32'sd1));
    send_request(make_req(ilst_pkg::OP_REMOVE, 200, 0));
    send_request(make_req(ilst_pkg::OP_NOP, 0, 0));
    send_request(make_req(ilst_pkg::OP_CLEAR, 0, 0));
    send_request(make_req(ilst_pkg::OP_GET, 0, 0));
  endtask

  // fill to capacity, then push against the limit
  task automatic test_full_list();
    send_request(make_req(ilst_pkg::OP_CLEAR, 0, 0));
    while (list_len < ilst_pkg::CAPACITY) begin
      if ($urandom_range(0, 1)) begin
        send_request(make_req(ilst_pkg::OP_APPEND, 0, pick_value()));
      end else begin
        send_request(make_req(ilst_pkg::OP_INSERT, $urandom_range(0, list_len), pick_value()));
      end
    end
    send_request(make_req(ilst_pkg::OP_APPEND, 0, 32'sd1));
    // full wins over a bad index
    send_request(make_req(ilst_pkg::OP_INSERT, 255, 32'sd1));
    send_request(make_req(ilst_pkg::OP_INSERT, 0, 32'sd1));
    send_request(make_req(ilst_pkg::OP_GET, ilst_pkg::CAPACITY - 1, 0));
    send_request(make_req(ilst_pkg::OP_FIND, 0, list_cells[ilst_pkg::CAPACITY-1]));
    send_request(make_req(ilst_pkg::OP_SET, ilst_pkg::CAPACITY - 1, 32'sh12345678));
    send_request(make_req(ilst_pkg::OP_REMOVE, ilst_pkg::CAPACITY - 1, 0));
    send_request(make_req(ilst_pkg::OP_INSERT, ilst_pkg::CAPACITY - 1, 32'sh7fffffff));
    send_request(make_req(ilst_pkg::OP_REMOVE, 0, 0));
    send_request(make_req(ilst_pkg::OP_GET, ilst_pkg::CAPACITY - 1, 0));
  endtask

  task automatic test_random_ops(input int n_items);
    int  k;
    int  roll;
    int  grow;
    ilst_pkg::op_e op;
    logic signed [ilst_pkg::DATA_W-1:0] val;
    grow = 50;
    for (k = 0; k < n_items; k++) begin
      // drift the list size between empty and full
      if (k % 120 == 0) grow = $urandom_range(15, 85);
      idle_pct = (k >= n_items / 3 && k < n_items / 3 + 250) ? 0 : 28;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = ilst_pkg::OP_CLEAR;
      else if (roll < 5) op = ilst_pkg::OP_NOP;
      else if ($urandom_range(0, 99) < grow) begin
        op = $urandom_range(0, 1) ? ilst_pkg::OP_APPEND : ilst_pkg::OP_INSERT;
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 4) op = ilst_pkg::OP_REMOVE;
        else if (roll < 6) op = ilst_pkg::OP_SET;
        else if (roll < 8) op = ilst_pkg::OP_GET;
        else op = ilst_pkg::OP_FIND;
      end
      val = pick_value();
      if (op == ilst_pkg::OP_FIND && list_len > 0 && $urandom_range(0, 99) < 60)
        val = list_cells[$urandom_range(0, list_len - 1)];
      send_request(make_req(op, pick_position(), val));
    end
  endtask

  initial begin
    list_len = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_random_ops(1000);
    start <= 1'b0;
    while (list_reports.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0 && list_reports.size() == 0) begin
      $display("tb_indexed_list_store_top OK");
    end else begin
      $display("tb_indexed_list_store_top NOT OK");
    end
    $finish;
  end

endmodule
